// ===== hdl/hbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared widths, opcodes and the result record of the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 15;
  localparam int LEN_W  = 4;
  localparam int ACC_W  = 7;
  localparam int CNT_W  = 3;
  localparam int PAD_W  = 4;
  localparam int TOT_W  = 5;
  localparam int COMB_W = ACC_W + CODE_W;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              is_final;
    logic [PAD_W-1:0]  pad_count;
    logic              last;
  } res_t;

endpackage

// ===== hdl/hbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hbp_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/huffman_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Table-driven Huffman encoder that packs code bits into bytes.
// ----------------------------------------------------------------------------
// An item is a load (write one symbol's code and length), an encode (append
// that symbol's code, first bit first, emitting each full byte MSB first) or
// a flush (pad with zeros and emit one final byte with its pad count). A new
// item can be taken while the pack stage finishes the last; an encode that
// yields two bytes writes both into the result buffer at once, and the result
// port hands out one byte per cycle while out_ready is high. The code table
// sits in a RAM read in the accept cycle; the bit accumulator is updated in
// the following stage. Results queue in a four-entry buffer, so input keeps
// flowing while a result waits, until more than two results are queued.
module huffman_bit_packer #(
  parameter int MAX_CODE_BITS = 15,
  parameter int SYMBOL_COUNT  = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hbp_pkg::OP_W-1:0]      in_op,
  input  logic [hbp_pkg::SYM_W-1:0]     in_symbol,
  input  logic [hbp_pkg::CODE_W-1:0]    in_code_value,
  input  logic [hbp_pkg::LEN_W-1:0]     in_code_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbp_pkg::BYTE_W-1:0]    out_packed_byte,
  output logic                          out_is_final,
  output logic [hbp_pkg::PAD_W-1:0]     out_pad_count,
  output logic                          out_last
);

  localparam int CW     = (MAX_CODE_BITS < hbp_pkg::CODE_W) ? MAX_CODE_BITS
                                                            : hbp_pkg::CODE_W;
  localparam int AW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int RAM_W  = CW + hbp_pkg::LEN_W;
  localparam int FIFO_D = 4;
  localparam int FP_W   = 2;
  localparam int FC_W   = 3;

  // ---------------- accept stage ----------------
  logic           in_acc;
  logic           in_range;
  logic           len_ok;
  logic [AW-1:0]  in_addr;
  logic [hbp_pkg::CODE_W-1:0] code_mask;
  logic [hbp_pkg::CODE_W-1:0] code_masked;
  logic           ram_we;
  logic           ram_re;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;

  logic [SYMBOL_COUNT-1:0] vld_r;
  logic                    s1_valid_r;
  logic                    s1_flush_r;
  logic                    s1_hit_r;
  logic                    s1_fire;

  assign in_acc      = in_valid && in_ready;
  assign in_range    = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));
  assign len_ok      = (32'(in_code_length) <= 32'(MAX_CODE_BITS));
  assign in_addr     = in_symbol[AW-1:0];
  assign code_mask   = hbp_pkg::CODE_W'((32'd1 << in_code_length) - 32'd1);
  assign code_masked = in_code_value & code_mask;
  assign ram_we      = in_acc && (in_op == hbp_pkg::OP_LOAD) && in_range && len_ok;
  assign ram_re      = in_acc && (in_op == hbp_pkg::OP_ENCODE);
  assign ram_wdata   = {in_code_length, code_masked[CW-1:0]};

  hbp_ram #(
    .WIDTH(RAM_W),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(in_addr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(in_addr),
    .rd_data(ram_rdata)
  );

  // ---------------- pack stage ----------------
  logic [hbp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hbp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [hbp_pkg::LEN_W-1:0]  len;
  logic [hbp_pkg::CODE_W-1:0] code;
  logic [hbp_pkg::COMB_W-1:0] comb;
  logic [hbp_pkg::TOT_W-1:0]  total;
  logic [hbp_pkg::PAD_W-1:0]  pad;
  logic [1:0]                 n_push;
  hbp_pkg::res_t              res0, res1;

  // an entry never written holds no defined code bits
  assign len  = s1_hit_r ? ram_rdata[RAM_W-1 -: hbp_pkg::LEN_W] : '0;
  assign code = s1_hit_r ? hbp_pkg::CODE_W'(ram_rdata[CW-1:0]) : '0;
  assign comb = (hbp_pkg::COMB_W'(acc_r) << len) | hbp_pkg::COMB_W'(code);
  assign total = hbp_pkg::TOT_W'(cnt_r) + hbp_pkg::TOT_W'(len);
  assign pad  = hbp_pkg::PAD_W'(hbp_pkg::BYTE_W) - hbp_pkg::PAD_W'(cnt_r);

  always_comb begin
    res0    = '0;
    res1    = '0;
    n_push  = 2'd0;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (s1_flush_r) begin
      // empty accumulator gives byte 0 and pad 8
      res0.packed_byte = hbp_pkg::BYTE_W'(acc_r) << pad;
      res0.is_final    = 1'b1;
      res0.pad_count   = pad;
      res0.last        = 1'b1;
      n_push           = 2'd1;
      acc_nxt          = '0;
      cnt_nxt          = '0;
    end else begin
      res0.packed_byte = hbp_pkg::BYTE_W'(comb >> (total - 5'd8));
      res1.packed_byte = hbp_pkg::BYTE_W'(comb >> (total - 5'd16));
      if (total >= 5'd16) begin
        n_push    = 2'd2;
        res1.last = 1'b1;
      end else if (total >= 5'd8) begin
        n_push    = 2'd1;
        res0.last = 1'b1;
      end
      // bits above total are zero, so only the low remainder is kept
      cnt_nxt = total[hbp_pkg::CNT_W-1:0];
      acc_nxt = comb[hbp_pkg::ACC_W-1:0] &
                hbp_pkg::ACC_W'((8'd1 << cnt_nxt) - 8'd1);
    end
  end

  // ---------------- result buffer ----------------
  hbp_pkg::res_t   fifo_r [FIFO_D];
  logic [FP_W-1:0] wp_r, rp_r;
  logic [FC_W-1:0] fcnt_r;
  logic            pop;
  logic [1:0]      n_eff;

  assign s1_fire  = s1_valid_r && (fcnt_r <= FC_W'(FIFO_D - 2));
  assign in_ready = !s1_valid_r || s1_fire;
  assign n_eff    = s1_fire ? n_push : 2'd0;
  assign pop      = out_valid && out_ready;

  assign out_valid       = (fcnt_r != '0);
  assign out_packed_byte = fifo_r[rp_r].packed_byte;
  assign out_is_final    = fifo_r[rp_r].is_final;
  assign out_pad_count   = fifo_r[rp_r].pad_count;
  assign out_last        = fifo_r[rp_r].last;

  always_ff @(posedge clk) begin
    if (n_eff != 2'd0) begin
      fifo_r[wp_r] <= res0;
    end
    if (n_eff == 2'd2) begin
      fifo_r[wp_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
      s1_hit_r   <= 1'b0;
      acc_r      <= '0;
      cnt_r      <= '0;
      wp_r       <= '0;
      rp_r       <= '0;
      fcnt_r     <= '0;
    end else begin
      if (ram_we) begin
        vld_r[in_addr] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid_r <= (in_op == hbp_pkg::OP_ENCODE) || (in_op == hbp_pkg::OP_FLUSH);
        s1_flush_r <= (in_op == hbp_pkg::OP_FLUSH);
        s1_hit_r   <= in_range && vld_r[in_addr];
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
      end
      wp_r   <= wp_r + FP_W'(n_eff);
      rp_r   <= rp_r + FP_W'(pop);
      fcnt_r <= fcnt_r + FC_W'(n_eff) - FC_W'(pop);
    end
  end

endmodule

// ===== hdl/hbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks on the result channel of the Huffman bit packer.
// ----------------------------------------------------------------------------
module hbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_packed_byte,
  input logic       out_is_final,
  input logic [3:0] out_pad_count,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packed_byte) &&
    $stable(out_is_final) && $stable(out_pad_count) && $stable(out_last))
    else $error("result item changed while stalled");

  a_final_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final |-> out_last && out_pad_count != 4'd0 &&
    out_pad_count <= 4'd8)
    else $error("flush item with bad pad count or without last");

  a_encode_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_pad_count == 4'd0)
    else $error("encode item with nonzero pad count");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (.*);

// ===== tb/packer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packer_checker
// Watches both channels of the bit packer and keeps its own copy of the code
// table and bit accumulator. Each accepted item is turned into the bytes it
// should produce. Each accepted result is compared field by field with the
// oldest of those bytes.
// ----------------------------------------------------------------------------
module packer_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [hbp_pkg::OP_W-1:0]   in_op,
  input  logic [hbp_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hbp_pkg::CODE_W-1:0] in_code_value,
  input  logic [hbp_pkg::LEN_W-1:0]  in_code_length,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [hbp_pkg::BYTE_W-1:0] out_packed_byte,
  input  logic                       out_is_final,
  input  logic [hbp_pkg::PAD_W-1:0]  out_pad_count,
  input  logic                       out_last,
  output int                         fail_count,
  output int                         pending_count
);

  logic [hbp_pkg::CODE_W-1:0] code_mem [256];
  logic [hbp_pkg::LEN_W-1:0]  len_mem  [256];
  logic [hbp_pkg::ACC_W-1:0]  acc_bits;
  logic [hbp_pkg::CNT_W-1:0]  acc_cnt;
  hbp_pkg::res_t              expected_bytes [$];
  int                         fails = 0;

  task automatic model_packing(input logic [hbp_pkg::OP_W-1:0] op,
                               input logic [hbp_pkg::SYM_W-1:0] sym,
                               input logic [hbp_pkg::CODE_W-1:0] val,
                               input logic [hbp_pkg::LEN_W-1:0] len);
    logic [hbp_pkg::COMB_W-1:0] combined;
    logic [hbp_pkg::COMB_W-1:0] mask;
    logic [hbp_pkg::TOT_W-1:0]  total;
    logic [hbp_pkg::LEN_W-1:0]  clen;
    logic [hbp_pkg::PAD_W-1:0]  pad;
    hbp_pkg::res_t              rec;
    case (op)
      hbp_pkg::OP_LOAD: begin
        // bits at and above the length are dropped
        mask = (hbp_pkg::COMB_W'(1) << len) - hbp_pkg::COMB_W'(1);
        code_mem[sym] = val & mask[hbp_pkg::CODE_W-1:0];
        len_mem[sym] = len;
      end
      hbp_pkg::OP_ENCODE: begin
        clen = len_mem[sym];
        if (clen != '0) begin
          combined = (hbp_pkg::COMB_W'(acc_bits) << clen) |
                     hbp_pkg::COMB_W'(code_mem[sym]);
          total = hbp_pkg::TOT_W'(acc_cnt) + hbp_pkg::TOT_W'(clen);
          while (total >= hbp_pkg::TOT_W'(hbp_pkg::BYTE_W)) begin
            rec.packed_byte = hbp_pkg::BYTE_W'(combined >>
                                               (total - hbp_pkg::TOT_W'(hbp_pkg::BYTE_W)));
            rec.is_final = 1'b0;
            rec.pad_count = '0;
            // last byte of this item when fewer than 16 bits remain
            rec.last = (total < hbp_pkg::TOT_W'(2 * hbp_pkg::BYTE_W));
            expected_bytes.push_back(rec);
            total = total - hbp_pkg::TOT_W'(hbp_pkg::BYTE_W);
          end
          mask = (hbp_pkg::COMB_W'(1) << total) - hbp_pkg::COMB_W'(1);
          acc_bits = hbp_pkg::ACC_W'(combined & mask);
          acc_cnt = hbp_pkg::CNT_W'(total);
        end
      end
      hbp_pkg::OP_FLUSH: begin
        pad = hbp_pkg::PAD_W'(hbp_pkg::BYTE_W) - hbp_pkg::PAD_W'(acc_cnt);
        rec.packed_byte = (acc_cnt == '0) ? '0 : ({1'b0, acc_bits} << pad);
        rec.is_final = 1'b1;
        rec.pad_count = pad;
        rec.last = 1'b1;
        expected_bytes.push_back(rec);
        acc_bits = '0;
        acc_cnt = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    hbp_pkg::res_t want;
    bit            bad;
    if (!rst_n) begin
      expected_bytes.delete();
      for (int i = 0; i < 256; i++) len_mem[i] = '0;
      acc_bits = '0;
      acc_cnt = '0;
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready)
        model_packing(in_op, in_symbol, in_code_value, in_code_length);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %02h with nothing pending", out_packed_byte);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          bad = 1'b0;
          if (out_packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, got %02h", want.packed_byte, out_packed_byte);
            bad = 1'b1;
          end
          if (out_is_final !== want.is_final) begin
            $error("is_final: expected %0b, got %0b", want.is_final, out_is_final);
            bad = 1'b1;
          end
          if (out_pad_count !== want.pad_count) begin
            $error("pad_count: expected %0d, got %0d", want.pad_count, out_pad_count);
            bad = 1'b1;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            bad = 1'b1;
          end
          if (bad) fails++;
        end
      end
      fail_count <= fails;
      pending_count <= expected_bytes.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the bit packer with directed and random load, encode, flush and
// unused-op items under random idling on both channels, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [hbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int MAX_GAP      = 6;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [hbp_pkg::OP_W-1:0]   in_op;
  logic [hbp_pkg::SYM_W-1:0]  in_symbol;
  logic [hbp_pkg::CODE_W-1:0] in_code_value;
  logic [hbp_pkg::LEN_W-1:0]  in_code_length;
  logic                       out_valid;
  logic                       out_ready;
  logic [hbp_pkg::BYTE_W-1:0] out_packed_byte;
  logic                       out_is_final;
  logic [hbp_pkg::PAD_W-1:0]  out_pad_count;
  logic                       out_last;
  int                         fail_count;
  int                         pending_count;

  bit                         loaded [256];
  logic [hbp_pkg::SYM_W-1:0]  loaded_syms [$];
  int                         tx_calm = 0;

  huffman_bit_packer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_byte(out_packed_byte),
    .out_is_final   (out_is_final),
    .out_pad_count  (out_pad_count),
    .out_last       (out_last)
  );

  packer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_byte(out_packed_byte),
    .out_is_final   (out_is_final),
    .out_pad_count  (out_pad_count),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin : watchdog
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_item(input logic [hbp_pkg::OP_W-1:0] op,
                           input logic [hbp_pkg::SYM_W-1:0] sym,
                           input logic [hbp_pkg::CODE_W-1:0] val,
                           input logic [hbp_pkg::LEN_W-1:0] len);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) tx_calm = 30;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op <= op;
    in_symbol <= sym;
    in_code_value <= val;
    in_code_length <= len;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    // random encodes pick only from symbols that have been loaded
    if (op == hbp_pkg::OP_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  task automatic send_random_load();
    logic [hbp_pkg::LEN_W-1:0] len;
    len = ($urandom_range(0, 9) == 0) ? '0 : hbp_pkg::LEN_W'($urandom_range(1, 15));
    send_item(hbp_pkg::OP_LOAD, hbp_pkg::SYM_W'($urandom), hbp_pkg::CODE_W'($urandom),
              len);
  endtask

  initial begin : stimulus
    int work_items;
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= hbp_pkg::OP_LOAD;
    in_symbol <= '0;
    in_code_value <= '0;
    in_code_length <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(hbp_pkg::OP_FLUSH, 8'h00, 15'h0000, 4'd0);     // flush with nothing pending
    send_item(OP_UNUSED, 8'hFF, 15'h7FFF, 4'd15);            // unused op
    send_item(hbp_pkg::OP_ENCODE, 8'h13, 15'h0000, 4'd0);    // symbol never loaded
    send_item(hbp_pkg::OP_LOAD, 8'h00, 15'h7FFF, 4'd15);
    send_item(hbp_pkg::OP_LOAD, 8'hFF, 15'h0001, 4'd1);
    send_item(hbp_pkg::OP_LOAD, 8'h80, 15'h7FFF, 4'd0);      // empty code
    send_item(hbp_pkg::OP_LOAD, 8'h55, 15'h7F5A, 4'd3);      // upper bits dropped
    send_item(hbp_pkg::OP_LOAD, 8'h2A, 15'h0000, 4'd8);
    send_item(hbp_pkg::OP_ENCODE, 8'h80, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_ENCODE, 8'hFF, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_ENCODE, 8'h00, 15'h0000, 4'd0);    // two bytes out
    send_item(hbp_pkg::OP_ENCODE, 8'h55, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_FLUSH, 8'h00, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_ENCODE, 8'h2A, 15'h0000, 4'd0);    // exactly one byte
    send_item(hbp_pkg::OP_ENCODE, 8'h00, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_ENCODE, 8'h00, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_FLUSH, 8'hFF, 15'h7FFF, 4'd15);
    send_item(hbp_pkg::OP_FLUSH, 8'h00, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_ENCODE, 8'hFF, 15'h7FFF, 4'd15);   // fields ignored on encode
    send_item(hbp_pkg::OP_LOAD, 8'hFF, 15'h5555, 4'd15);     // overwrite entry
    send_item(hbp_pkg::OP_ENCODE, 8'hFF, 15'h0000, 4'd0);
    send_item(hbp_pkg::OP_FLUSH, 8'h00, 15'h0000, 4'd0);

    repeat (40) send_random_load();
    work_items = 40;
    while (work_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_random_load();
        work_items++;
      end else if (pick < 82) begin
        send_item(hbp_pkg::OP_ENCODE,
                  loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                  hbp_pkg::CODE_W'($urandom), hbp_pkg::LEN_W'($urandom));
        work_items++;
      end else if (pick < 95) begin
        send_item(hbp_pkg::OP_FLUSH, hbp_pkg::SYM_W'($urandom),
                  hbp_pkg::CODE_W'($urandom), hbp_pkg::LEN_W'($urandom));
        work_items++;
      end else begin
        send_item(OP_UNUSED, hbp_pkg::SYM_W'($urandom),
                  hbp_pkg::CODE_W'($urandom), hbp_pkg::LEN_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    int rx_count;
    int rx_calm;
    rx_count = 0;
    rx_calm = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // long holds let the result buffer fill and back up the input
      if (rx_count == 40 || rx_count == 900) begin
        gap = LONG_HOLD;
      end else if (rx_calm > 0) begin
        gap = 0;
        rx_calm--;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) rx_calm = 30;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      rx_count++;
    end
  end

endmodule

// ===== sim.f =====
hdl/hbp_pkg.sv
hdl/hbp_ram.sv
hdl/huffman_bit_packer.sv
hdl/hbp_checker.sv
tb/packer_checker.sv
tb/testbench.sv
